@@ sv/fpn_pkg.sv @@
package fpn_pkg;

    // default geometry
    localparam int MAX_OCTAVES_DEF     = 8;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int COORD_W = 32;
    localparam int FREQ_W  = 24;
    localparam int OCTC_W  = 4;
    localparam int PERS_W  = 16;
    localparam int OUT_W   = 19;
    localparam int FRAC_W  = 16;
    localparam int FADE_W  = 17;
    localparam int AMP_W   = 17;
    localparam int LERP_W  = 20;
    localparam int TAB_W   = 8;
    localparam int TAB_D   = 256;
    localparam int CFGI_W  = 8;
    localparam int CFGD_W  = 32;

    localparam int ONE_Q16 = 65536;
    localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(131072);

    // reset values of the registers
    localparam logic [FREQ_W-1:0] BASE_SCALE_RST  = FREQ_W'(65536);
    localparam logic [OCTC_W-1:0] OCTAVE_CNT_RST  = OCTC_W'(1);
    localparam logic [PERS_W-1:0] PERSISTENCE_RST = PERS_W'(32768);
    localparam logic [FREQ_W-1:0] LACUNARITY_RST  = FREQ_W'(131072);

    // register indexes
    localparam logic [CFGI_W-1:0] CFG_BASE_SCALE  = CFGI_W'(0);
    localparam logic [CFGI_W-1:0] CFG_OCTAVE_CNT  = CFGI_W'(1);
    localparam logic [CFGI_W-1:0] CFG_PERSISTENCE = CFGI_W'(2);
    localparam logic [CFGI_W-1:0] CFG_LACUNARITY  = CFGI_W'(3);

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef logic signed [LERP_W-1:0] t_lerp;

    // gradient from one of the 12 cube edge directions
    function automatic t_lerp grad3(input logic [3:0] h, input t_lerp x, input t_lerp y,
                                    input t_lerp z);
        t_lerp u;
        t_lerp v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : (((h == 4'd12) || (h == 4'd14)) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

@@ sv/fpn_ram.sv @@
module fpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/fpn_div.sv @@
module fpn_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_sub;
    logic             w_ge;

    // restoring step: one quotient bit a cycle
    assign w_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_ge  = (w_sh >= {1'b0, r_den});
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_sub) : DEN_W'(w_sh);
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ sv/fractal_perlin_noise_3d.sv @@
// Channel  Direction  Handshake                   Word
// in       input      i_in_valid / o_in_ready     command, table entry, point
// cfg      input      i_cfg_valid / o_cfg_ready   register index, data
// out      output     o_out_valid / i_out_ready   noise_value
//
// A load word is written to the table when accepted. A sample runs per octave
// through split, a table walk with 14 permutation reads through the registered
// RAM port, gradient, 7 blend steps on one multiplier and accumulate, then the
// bit-serial divide and the hand-over, and returns to idle before the next word.
// Reset is synchronous, active low; the table holds garbage until loaded.
// The result waits in an output register; a stalled output holds back only
// the hand-over of the next result.
module fractal_perlin_noise_3d #(
    parameter int MAX_OCTAVES     = fpn_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = fpn_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [fpn_pkg::TAB_W-1:0]          i_table_index,
    input  logic [fpn_pkg::TAB_W-1:0]          i_table_value,
    input  logic signed [fpn_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [fpn_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [fpn_pkg::COORD_W-1:0] i_coord_z,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fpn_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [fpn_pkg::CFGD_W-1:0]         i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [fpn_pkg::OUT_W-1:0]   o_noise_value
);

    localparam int OC_W  = $clog2(MAX_OCTAVES + 1);
    localparam int TOT_W = 38 + OC_W;
    localparam int WGT_W = fpn_pkg::AMP_W + OC_W;
    localparam int PRD_W = fpn_pkg::COORD_W + fpn_pkg::FREQ_W + 1;
    localparam int DOWN  = (COORD_FRAC_BITS >= 16) ? (COORD_FRAC_BITS - 16) : 0;
    localparam int UP    = (COORD_FRAC_BITS < 16) ? (16 - COORD_FRAC_BITS) : 0;
    localparam logic [PRD_W-1:0] FRAC_MASK = (PRD_W'(1) << COORD_FRAC_BITS) - PRD_W'(1);
    localparam logic [3:0] READ_LAST  = 4'd14;
    localparam logic [3:0] BLEND_LAST = 4'd6;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SPLIT = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_GRAD  = 8'b0000_1000,
        ST_BLEND = 8'b0001_0000,
        ST_ACC   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [fpn_pkg::FREQ_W-1:0] r_base_scale;
    logic [fpn_pkg::OCTC_W-1:0] r_octave_cnt;
    logic [fpn_pkg::PERS_W-1:0] r_persistence;
    logic [fpn_pkg::FREQ_W-1:0] r_lacunarity;

    // per-sample working registers
    logic signed [fpn_pkg::COORD_W-1:0] r_coord [3];
    logic [fpn_pkg::FREQ_W-1:0]         r_freq;
    logic [fpn_pkg::AMP_W-1:0]          r_amp;
    logic signed [TOT_W-1:0]            r_total;
    logic [WGT_W-1:0]                   r_weight;
    logic [OC_W-1:0]                    r_oct;
    logic [OC_W-1:0]                    r_oct_num;
    logic [3:0]                         r_step;
    logic [fpn_pkg::TAB_W-1:0]          r_cell [3];
    logic [fpn_pkg::FRAC_W-1:0]         r_frac [3];
    logic [fpn_pkg::FRAC_W-1:0]         r_t2 [3];
    logic [fpn_pkg::FADE_W-1:0]         r_fade [3];
    logic [fpn_pkg::TAB_W-1:0]          r_ha, r_hb, r_haa, r_hab, r_hba, r_hbb;
    logic [31:0]                        r_hash;
    fpn_pkg::t_lerp                     r_lv [8];
    logic                               r_div_start;
    logic                               r_out_valid;
    logic signed [fpn_pkg::OUT_W-1:0]   r_noise;

    logic                      w_in_acc;
    logic                      w_load;
    logic [fpn_pkg::TAB_W-1:0] w_raddr;
    logic [fpn_pkg::TAB_W-1:0] w_rdata;
    logic [PRD_W-1:0]          w_prod [3];
    logic                      w_last_oct;
    logic                      w_div_done;
    logic [TOT_W-1:0]          w_quot;
    logic [TOT_W-1:0]          w_mag;
    logic [fpn_pkg::OUT_W-1:0] w_sat;
    logic                      w_out_free;
    fpn_pkg::t_lerp            w_ba, w_bb;
    logic [fpn_pkg::FADE_W-1:0] w_bt;
    logic signed [fpn_pkg::LERP_W:0] w_diff;
    logic signed [38:0]        w_bprod;
    fpn_pkg::t_lerp            w_bres;
    logic signed [37:0]        w_aprod;
    logic [32:0]               w_pprod;
    logic [47:0]               w_fprod;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_load      = w_in_acc && (i_command == fpn_pkg::CMD_LOAD);
    assign w_last_oct  = (OC_W'(r_oct + 1'b1) == r_oct_num);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_scale  <= fpn_pkg::BASE_SCALE_RST;
            r_octave_cnt  <= fpn_pkg::OCTAVE_CNT_RST;
            r_persistence <= fpn_pkg::PERSISTENCE_RST;
            r_lacunarity  <= fpn_pkg::LACUNARITY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fpn_pkg::CFG_BASE_SCALE:  r_base_scale  <= i_cfg_data[fpn_pkg::FREQ_W-1:0];
                fpn_pkg::CFG_OCTAVE_CNT:  r_octave_cnt  <= i_cfg_data[fpn_pkg::OCTC_W-1:0];
                fpn_pkg::CFG_PERSISTENCE: r_persistence <= i_cfg_data[fpn_pkg::PERS_W-1:0];
                fpn_pkg::CFG_LACUNARITY:  r_lacunarity  <= i_cfg_data[fpn_pkg::FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    // permutation table
    fpn_ram #(
        .WIDTH (fpn_pkg::TAB_W),
        .DEPTH (fpn_pkg::TAB_D)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // read address sequence over the hash chain
    always_comb begin
        case (r_step)
            4'd0:    w_raddr = r_cell[0];
            4'd1:    w_raddr = r_cell[0] + 1'b1;
            4'd2:    w_raddr = r_ha;
            4'd3:    w_raddr = r_ha + 1'b1;
            4'd4:    w_raddr = r_hb;
            4'd5:    w_raddr = r_hb + 1'b1;
            4'd6:    w_raddr = r_haa;
            4'd7:    w_raddr = r_hba;
            4'd8:    w_raddr = r_hab;
            4'd9:    w_raddr = r_hbb;
            4'd10:   w_raddr = r_haa + 1'b1;
            4'd11:   w_raddr = r_hba + 1'b1;
            4'd12:   w_raddr = r_hab + 1'b1;
            4'd13:   w_raddr = r_hbb + 1'b1;
            default: w_raddr = r_cell[0];
        endcase
    end

    // point times frequency, one product per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_prod[a] = PRD_W'($signed(r_coord[a]) * $signed({1'b0, r_freq}));
        end
    end

    // blend operands by step
    always_comb begin
        case (r_step)
            4'd0:    begin w_ba = r_lv[0]; w_bb = r_lv[1]; w_bt = r_fade[0]; end
            4'd1:    begin w_ba = r_lv[2]; w_bb = r_lv[3]; w_bt = r_fade[0]; end
            4'd2:    begin w_ba = r_lv[4]; w_bb = r_lv[5]; w_bt = r_fade[0]; end
            4'd3:    begin w_ba = r_lv[6]; w_bb = r_lv[7]; w_bt = r_fade[0]; end
            4'd4:    begin w_ba = r_lv[0]; w_bb = r_lv[1]; w_bt = r_fade[1]; end
            4'd5:    begin w_ba = r_lv[2]; w_bb = r_lv[3]; w_bt = r_fade[1]; end
            4'd6:    begin w_ba = r_lv[0]; w_bb = r_lv[1]; w_bt = r_fade[2]; end
            default: begin w_ba = r_lv[0]; w_bb = r_lv[1]; w_bt = r_fade[2]; end
        endcase
        w_diff  = {w_bb[fpn_pkg::LERP_W-1], w_bb} - {w_ba[fpn_pkg::LERP_W-1], w_ba};
        w_bprod = $signed({1'b0, w_bt}) * w_diff;
        w_bres  = w_ba + fpn_pkg::LERP_W'(w_bprod >>> 16);
    end

    // octave bookkeeping products
    assign w_aprod = $signed(r_lv[0]) * $signed({1'b0, r_amp});
    assign w_pprod = r_amp * r_persistence;
    assign w_fprod = r_freq * r_lacunarity;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            // result word: raised on hand-over, dropped once taken
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_command == fpn_pkg::CMD_SAMPLE)) begin
                        r_state <= ST_SPLIT;
                    end
                end
                ST_SPLIT: begin
                    r_state <= ST_READ;
                    r_step  <= '0;
                end
                ST_READ: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == READ_LAST) begin
                        r_state <= ST_GRAD;
                    end
                end
                ST_GRAD: begin
                    r_state <= ST_BLEND;
                    r_step  <= '0;
                end
                ST_BLEND: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == BLEND_LAST) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (w_last_oct) begin
                        r_state     <= ST_DIV;
                        r_div_start <= 1'b1;
                    end else begin
                        r_state <= ST_SPLIT;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_coord[0] <= i_coord_x;
                r_coord[1] <= i_coord_y;
                r_coord[2] <= i_coord_z;
                r_freq     <= r_base_scale;
                r_amp      <= fpn_pkg::AMP_W'(fpn_pkg::ONE_Q16);
                r_total    <= '0;
                r_weight   <= '0;
                r_oct      <= '0;
                if (r_octave_cnt == '0) begin
                    r_oct_num <= OC_W'(1);
                end else if (32'(r_octave_cnt) > MAX_OCTAVES) begin
                    r_oct_num <= OC_W'(MAX_OCTAVES);
                end else begin
                    r_oct_num <= OC_W'(r_octave_cnt);
                end
            end
            ST_SPLIT: begin
                for (int a = 0; a < 3; a++) begin
                    r_cell[a] <= fpn_pkg::TAB_W'(w_prod[a] >> (16 + COORD_FRAC_BITS));
                    r_frac[a] <= fpn_pkg::FRAC_W'((((w_prod[a] >> 16) & FRAC_MASK) >> DOWN)
                                                  << UP);
                end
            end
            ST_READ: begin
                // fade in two multiplies while the table is walked
                for (int a = 0; a < 3; a++) begin
                    if (r_step == 4'd0) begin
                        r_t2[a] <= fpn_pkg::FRAC_W'((32'(r_frac[a]) * 32'(r_frac[a])) >> 16);
                    end
                    if (r_step == 4'd1) begin
                        r_fade[a] <= fpn_pkg::FADE_W'((34'(r_t2[a])
                            * 34'(18'(3 * fpn_pkg::ONE_Q16) - 18'({r_frac[a], 1'b0}))) >> 16);
                    end
                end
                case (r_step)
                    4'd1:    r_ha  <= w_rdata + r_cell[1];
                    4'd2:    r_hb  <= w_rdata + r_cell[1];
                    4'd3:    r_haa <= w_rdata + r_cell[2];
                    4'd4:    r_hab <= w_rdata + r_cell[2];
                    4'd5:    r_hba <= w_rdata + r_cell[2];
                    4'd6:    r_hbb <= w_rdata + r_cell[2];
                    default: ;
                endcase
                if (r_step >= 4'd7) begin
                    r_hash <= {r_hash[27:0], w_rdata[3:0]};
                end
            end
            ST_GRAD: begin
                // corner i: x offset from bit 0, y from bit 1, z from bit 2
                for (int i = 0; i < 8; i++) begin
                    r_lv[i] <= fpn_pkg::grad3(r_hash[31-4*i -: 4],
                        i[0] ? fpn_pkg::LERP_W'(r_frac[0]) - fpn_pkg::LERP_W'(fpn_pkg::ONE_Q16)
                             : fpn_pkg::LERP_W'(r_frac[0]),
                        i[1] ? fpn_pkg::LERP_W'(r_frac[1]) - fpn_pkg::LERP_W'(fpn_pkg::ONE_Q16)
                             : fpn_pkg::LERP_W'(r_frac[1]),
                        i[2] ? fpn_pkg::LERP_W'(r_frac[2]) - fpn_pkg::LERP_W'(fpn_pkg::ONE_Q16)
                             : fpn_pkg::LERP_W'(r_frac[2]));
                end
            end
            ST_BLEND: begin
                case (r_step)
                    4'd0, 4'd4, 4'd6: r_lv[0] <= w_bres;
                    4'd1, 4'd5:       r_lv[1] <= w_bres;
                    4'd2:             r_lv[2] <= w_bres;
                    4'd3:             r_lv[3] <= w_bres;
                    default: ;
                endcase
            end
            ST_ACC: begin
                r_total  <= r_total + TOT_W'(w_aprod);
                r_weight <= r_weight + WGT_W'(r_amp);
                r_amp    <= fpn_pkg::AMP_W'(w_pprod >> 16);
                r_freq   <= (w_fprod[47:40] != '0) ? '1 : w_fprod[39:16];
                r_oct    <= OC_W'(r_oct + 1'b1);
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_noise <= r_total[TOT_W-1] ? -$signed(w_sat) : $signed(w_sat);
                end
            end
            default: ;
        endcase
    end

    // magnitude divide, sign applied afterwards (truncation toward zero)
    assign w_mag = r_total[TOT_W-1] ? TOT_W'(-r_total) : TOT_W'(r_total);
    assign w_sat = (w_quot > TOT_W'(fpn_pkg::OUT_MAX)) ? fpn_pkg::OUT_MAX
                                                       : fpn_pkg::OUT_W'(w_quot);

    fpn_div #(
        .NUM_W (TOT_W),
        .DEN_W (WGT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_mag),
        .i_den   (r_weight),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_noise;

    // the divisor always holds at least the first octave's weight
    a_weight_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_weight != '0))
        else $error("divide started with zero weight");

    // the divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divide result outside divide state");

    // table walk never runs past its last read
    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_step <= READ_LAST))
        else $error("table walk overran");

    // octave index stays under the latched count
    a_oct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> (r_oct < r_oct_num))
        else $error("octave index beyond count");

endmodule
